FILE: design/cfc_pkg.sv
// Shared types and constants of the component to binary32 converter.
package cfc_pkg;

    // Source type codes held in the source_type register
    typedef enum logic [3:0] {
        SRC_FLOAT  = 4'd0,
        SRC_HALF   = 4'd1,
        SRC_DOUBLE = 4'd2,
        SRC_S8     = 4'd3,
        SRC_U8     = 4'd4,
        SRC_S16    = 4'd5,
        SRC_U16    = 4'd6,
        SRC_S32    = 4'd7,
        SRC_U32    = 4'd8,
        SRC_S64    = 4'd9,
        SRC_U64    = 4'd10
    } src_type_t;

    // Configuration register indexes
    localparam logic [3:0] REG_SOURCE_TYPE    = 4'd0;
    localparam logic [3:0] REG_NORMALIZE_MODE = 4'd1;

    localparam logic [31:0] INF_BITS       = 32'h7f80_0000;
    localparam logic [31:0] ONE_BITS       = 32'h3f80_0000;
    localparam logic [31:0] MINUS_ONE_BITS = 32'hbf80_0000;
    localparam logic [31:0] QNAN_BIT       = 32'h0040_0000;

    // Decoded operand: value = mag * 2^adj, or a finished special pattern
    typedef struct packed {
        logic               special;
        logic [31:0]        spec_bits;
        logic               sign;
        logic [63:0]        mag;
        logic signed [12:0] adj;
        logic               sticky;
    } dec_t;

    // Operand with its leading zero count
    typedef struct packed {
        dec_t       dec;
        logic [5:0] lz;
    } lzc_t;

    // Left-aligned significand and unbiased exponent of its top bit
    typedef struct packed {
        logic               special;
        logic [31:0]        spec_bits;
        logic               sign;
        logic [63:0]        mn;
        logic signed [12:0] e;
        logic               sticky;
    } aligned_t;

    // Kept significand bits ready for the rounding increment
    typedef struct packed {
        logic        special;
        logic [31:0] spec_bits;
        logic        sign;
        logic [7:0]  expf;
        logic [23:0] keep;
        logic        rnd;
        logic        st;
    } keep_t;

endpackage

FILE: design/cfc_if.sv
// Valid/ready channel interfaces of the converter.
interface cfc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] raw_component;

    modport source (output valid, output raw_component, input ready);
    modport sink (input valid, input raw_component, output ready);
endinterface

interface cfc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;

    modport source (output valid, output float_bits, input ready);
    modport sink (input valid, input float_bits, output ready);
endinterface

interface cfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/cfc_decode.sv
// Stage 1: decode the raw component into magnitude, scale and specials.
module cfc_decode
    import cfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] raw,
    input  logic [3:0]  source_type,
    input  logic        normalize_mode,
    output logic        valid_reg,
    output dec_t        dec_reg
);

    dec_t dec_next;

    // Split each source format into sign, magnitude and power-of-two scale
    always_comb
    begin
        logic [4:0]  hex;
        logic [9:0]  hman;
        logic [10:0] dex;
        logic [51:0] dfrac;
        logic [7:0]  m8;
        logic [15:0] m16;
        logic [31:0] m32;
        logic [63:0] m64;

        hex   = raw[14:10];
        hman  = raw[9:0];
        dex   = raw[62:52];
        dfrac = raw[51:0];
        m8    = raw[7] ? (~raw[7:0] + 8'd1) : raw[7:0];
        m16   = raw[15] ? (~raw[15:0] + 16'd1) : raw[15:0];
        m32   = raw[31] ? (~raw[31:0] + 32'd1) : raw[31:0];
        m64   = raw[63] ? (~raw + 64'd1) : raw;

        dec_next.special   = 1'b0;
        dec_next.spec_bits = '0;
        dec_next.sign      = 1'b0;
        dec_next.mag       = '0;
        dec_next.adj       = '0;
        dec_next.sticky    = 1'b0;

        case (source_type)
            SRC_FLOAT:
            begin
                dec_next.special   = 1'b1;
                dec_next.spec_bits = raw[31:0];
            end
            SRC_HALF:
            begin
                dec_next.sign = raw[15];
                if (hex == 5'h1f)
                begin
                    dec_next.special   = 1'b1;
                    dec_next.spec_bits = {raw[15], 31'b0} | INF_BITS | {9'b0, hman, 13'b0};
                end
                else if (hex == 5'd0)
                begin
                    dec_next.mag = {54'b0, hman};
                    dec_next.adj = -13'sd24;
                end
                else
                begin
                    dec_next.mag = {53'b0, 1'b1, hman};
                    dec_next.adj = $signed({8'b0, hex}) - 13'sd25;
                end
            end
            SRC_DOUBLE:
            begin
                dec_next.sign = raw[63];
                if (dex == 11'h7ff)
                begin
                    dec_next.special = 1'b1;
                    if (dfrac == '0)
                        dec_next.spec_bits = {raw[63], 31'b0} | INF_BITS;
                    else
                        dec_next.spec_bits = {raw[63], 31'b0} | INF_BITS | QNAN_BIT
                                           | {9'b0, dfrac[51:29]};
                end
                else if (dex == 11'd0)
                begin
                    dec_next.mag = {12'b0, dfrac};
                    dec_next.adj = -13'sd1074;
                end
                else
                begin
                    dec_next.mag = {11'b0, 1'b1, dfrac};
                    dec_next.adj = $signed({2'b0, dex}) - 13'sd1075;
                end
            end
            SRC_S8:
            begin
                dec_next.sign = raw[7];
                if (!normalize_mode)
                    dec_next.mag = {56'b0, m8};
                else if (m8[7] || m8 == 8'd127)
                begin
                    dec_next.special   = 1'b1;
                    dec_next.spec_bits = raw[7] ? MINUS_ONE_BITS : ONE_BITS;
                end
                else
                begin
                    // n/127 is the 7-bit pattern of n repeated without end
                    dec_next.mag    = {{9{m8[6:0]}}, m8[6]};
                    dec_next.adj    = -13'sd64;
                    dec_next.sticky = 1'b1;
                end
            end
            SRC_U8:
            begin
                if (!normalize_mode)
                    dec_next.mag = {56'b0, raw[7:0]};
                else if (raw[7:0] == 8'hff)
                begin
                    dec_next.special   = 1'b1;
                    dec_next.spec_bits = ONE_BITS;
                end
                else
                begin
                    dec_next.mag    = {8{raw[7:0]}};
                    dec_next.adj    = -13'sd64;
                    dec_next.sticky = 1'b1;
                end
            end
            SRC_S16:
            begin
                dec_next.sign = raw[15];
                if (!normalize_mode)
                    dec_next.mag = {48'b0, m16};
                else if (m16[15] || m16 == 16'd32767)
                begin
                    dec_next.special   = 1'b1;
                    dec_next.spec_bits = raw[15] ? MINUS_ONE_BITS : ONE_BITS;
                end
                else
                begin
                    dec_next.mag    = {{4{m16[14:0]}}, m16[14:11]};
                    dec_next.adj    = -13'sd64;
                    dec_next.sticky = 1'b1;
                end
            end
            SRC_U16:
            begin
                if (!normalize_mode)
                    dec_next.mag = {48'b0, raw[15:0]};
                else if (raw[15:0] == 16'hffff)
                begin
                    dec_next.special   = 1'b1;
                    dec_next.spec_bits = ONE_BITS;
                end
                else
                begin
                    dec_next.mag    = {4{raw[15:0]}};
                    dec_next.adj    = -13'sd64;
                    dec_next.sticky = 1'b1;
                end
            end
            SRC_S32:
            begin
                dec_next.sign = raw[31];
                dec_next.mag  = {32'b0, m32};
            end
            SRC_U32:  dec_next.mag = {32'b0, raw[31:0]};
            SRC_S64:
            begin
                dec_next.sign = raw[63];
                dec_next.mag  = m64;
            end
            SRC_U64:  dec_next.mag = raw;
            default:
            begin
                dec_next.special   = 1'b1;
                dec_next.spec_bits = '0;
            end
        endcase

        // Zero magnitude gives a signed zero
        if (!dec_next.special && dec_next.mag == '0)
        begin
            dec_next.special   = 1'b1;
            dec_next.spec_bits = {dec_next.sign, 31'b0};
        end
    end

    // Advance the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dec_reg <= dec_next;
    end

endmodule

FILE: design/cfc_normalize.sv
// Stages 2 and 3: count leading zeros, then left-align the significand.
module cfc_normalize
    import cfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en_lzc,
    input  logic     en_align,
    input  logic     in_valid,
    input  dec_t     dec,
    output logic     lzc_valid_reg,
    output logic     align_valid_reg,
    output aligned_t align_reg
);

    lzc_t     lzc_reg;
    lzc_t     lzc_next;
    aligned_t align_next;

    // Find the top set bit of the magnitude
    always_comb
    begin
        lzc_next.dec = dec;
        lzc_next.lz  = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (dec.mag[i])
                lzc_next.lz = 6'(63 - i);
        end
    end

    // Shift the top bit to bit 63 and form its exponent
    always_comb
    begin
        align_next.special   = lzc_reg.dec.special;
        align_next.spec_bits = lzc_reg.dec.spec_bits;
        align_next.sign      = lzc_reg.dec.sign;
        align_next.sticky    = lzc_reg.dec.sticky;
        align_next.mn        = lzc_reg.dec.mag << lzc_reg.lz;
        align_next.e         = $signed(13'd63 - {7'b0, lzc_reg.lz}) + lzc_reg.dec.adj;
    end

    // Advance both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lzc_valid_reg   <= 1'b0;
            align_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_lzc)
                lzc_valid_reg <= in_valid;
            if (en_align)
                align_valid_reg <= lzc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_lzc)
            lzc_reg <= lzc_next;
        if (en_align)
            align_reg <= align_next;
    end

endmodule

FILE: design/cfc_round.sv
// Stages 4 and 5: subnormal shift, round to nearest even and pack.
module cfc_round
    import cfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en_keep,
    input  logic        en_pack,
    input  logic        in_valid,
    input  aligned_t    align,
    output logic        keep_valid_reg,
    output logic        pack_valid_reg,
    output logic [31:0] float_bits_reg
);

    keep_t       keep_reg;
    keep_t       keep_next;
    logic [31:0] float_bits_next;

    // Pick the kept bits, shifting right further for subnormal results
    always_comb
    begin
        logic [4:0]         dsh;
        logic signed [12:0] under;
        logic [63:0]        shifted;
        logic               lost;

        under = -13'sd126 - align.e;
        if (align.e >= -13'sd126)
            dsh = '0;
        else if (under > 13'sd26)
            dsh = 5'd26;
        else
            dsh = under[4:0];

        shifted = align.mn >> dsh;
        lost    = (align.mn & ((64'd1 << dsh) - 64'd1)) != '0;

        keep_next.special   = align.special;
        keep_next.spec_bits = align.spec_bits;
        keep_next.sign      = align.sign;
        keep_next.expf      = (align.e >= -13'sd126) ? 8'(align.e + 13'sd126) : 8'd0;
        keep_next.keep      = shifted[63:40];
        keep_next.rnd       = shifted[39];
        keep_next.st        = (shifted[38:0] != '0) | lost | align.sticky;

        // Overflow saturates to a signed infinity
        if (!align.special && align.e > 13'sd127)
        begin
            keep_next.special   = 1'b1;
            keep_next.spec_bits = {align.sign, 31'b0} | INF_BITS;
        end
    end

    // Add the rounding increment; a carry moves into the exponent field
    always_comb
    begin
        logic [30:0] total;
        logic        inc;

        inc   = keep_reg.rnd & (keep_reg.st | keep_reg.keep[0]);
        total = {keep_reg.expf, 23'b0} + {7'b0, keep_reg.keep} + {30'b0, inc};
        float_bits_next = keep_reg.special ? keep_reg.spec_bits : {keep_reg.sign, total};
    end

    // Advance both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_valid_reg <= 1'b0;
            pack_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_keep)
                keep_valid_reg <= in_valid;
            if (en_pack)
                pack_valid_reg <= keep_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_keep)
            keep_reg <= keep_next;
        if (en_pack)
            float_bits_reg <= float_bits_next;
    end

endmodule

FILE: design/component_to_float_converter_core.sv
// Top level of the component to binary32 converter pipeline.
//
//  channel       | dir | payload                  | handshake
//  component_in  | in  | raw_component[63:0]      | valid/ready
//  float_out     | out | float_bits[31:0]         | valid/ready
//  cfg           | in  | index[3:0], data[31:0]   | valid/ready, ready always high
//
// One transaction per cycle while float_out is not stalled; the stages are
// decode, leading zero count, alignment, subnormal shift, round and pack. Each
// stage holds its own valid bit and loads when it is empty or the stage after
// it moves, so a stalled output fills the bubbles before input ready drops.
// Reset clears the valid bits and sets source_type and normalize_mode to zero.
module component_to_float_converter_core
    import cfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    cfc_in_if.sink   component_in,
    cfc_out_if.source float_out,
    cfc_cfg_if.sink  cfg
);

    logic [3:0] source_type_reg;
    logic       normalize_mode_reg;

    logic     v1, v2, v3, v4, v5;
    logic     en1, en2, en3, en4, en5;
    dec_t     dec;
    aligned_t align;

    // Take configuration writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_type_reg    <= SRC_FLOAT;
            normalize_mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_SOURCE_TYPE)
                source_type_reg <= cfg.data[3:0];
            else if (cfg.index == REG_NORMALIZE_MODE)
                normalize_mode_reg <= cfg.data[0];
        end
    end

    // Stage enables: load when empty or when the next stage moves
    assign en5 = !v5 || float_out.ready;
    assign en4 = !v4 || en5;
    assign en3 = !v3 || en4;
    assign en2 = !v2 || en3;
    assign en1 = !v1 || en2;

    assign component_in.ready = en1;

    cfc_decode u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en1),
        .in_valid       (component_in.valid),
        .raw            (component_in.raw_component),
        .source_type    (source_type_reg),
        .normalize_mode (normalize_mode_reg),
        .valid_reg      (v1),
        .dec_reg        (dec)
    );

    cfc_normalize u_normalize (
        .clk             (clk),
        .rst_n           (rst_n),
        .en_lzc          (en2),
        .en_align        (en3),
        .in_valid        (v1),
        .dec             (dec),
        .lzc_valid_reg   (v2),
        .align_valid_reg (v3),
        .align_reg       (align)
    );

    cfc_round u_round (
        .clk            (clk),
        .rst_n          (rst_n),
        .en_keep        (en4),
        .en_pack        (en5),
        .in_valid       (v3),
        .align          (align),
        .keep_valid_reg (v4),
        .pack_valid_reg (v5),
        .float_bits_reg (float_out.float_bits)
    );

    assign float_out.valid = v5;

`ifndef SYNTHESIS
    // Input stalls only when every stage holds a transaction
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !component_in.ready |-> (v1 && v2 && v3 && v4 && v5))
        else $error("input stalled with a bubble in the pipeline");

    // A waiting transaction in stage 4 is not dropped while the output holds
    a_keep_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v4 && !en5) |=> v4)
        else $error("stage 4 transaction lost during stall");

    // A new output comes only from a transaction in stage 4
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(float_out.valid) |-> $past(v4))
        else $error("output valid without a transaction behind it");
`endif

endmodule
